/* rtl/txt_pkg.sv */
// txt_pkg: shared types and constants of the text-mode terminal
`default_nettype none

package txt_pkg;

	localparam int ROW_W  = 5;
	localparam int COL_W  = 7;
	localparam int CHAR_W = 8;
	localparam int CELL_W = 16;

	localparam logic OP_PUT  = 1'b0;
	localparam logic OP_READ = 1'b1;

	localparam logic [CHAR_W-1:0] CH_SPACE     = 8'h20;
	localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;
	localparam logic [CHAR_W-1:0] CH_RETURN    = 8'd13;
	localparam logic [CHAR_W-1:0] CH_TAB       = 8'd9;
	localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;

	localparam logic [CELL_W-1:0] RESET_CELL  = 16'h0720;
	localparam logic [CHAR_W-1:0] RESET_COLOR = 8'h07;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = 2;

	typedef enum logic [2:0] {
		KIND_PUT_CHAR,
		KIND_NEWLINE,
		KIND_RETURN,
		KIND_TAB,
		KIND_BACKSPACE,
		KIND_READ,
		KIND_READ_NONE
	} kind_t;

	typedef struct packed {
		kind_t             kind;
		logic [CHAR_W-1:0] ch;
		logic [ROW_W-1:0]  row;
		logic [COL_W-1:0]  col;
	} queue_entry_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_ROW,
		ST_ADDR,
		ST_MEM,
		ST_NEWLINE,
		ST_BLANK,
		ST_RESP
	} back_state_t;

endpackage

`default_nettype wire

/* rtl/text_mode_terminal_top.sv */
// text_mode_terminal_top: character-cell text terminal, top level
//
//   channel  signals                                            role
//   in       in_valid/in_stall, operation, char_code,            request in
//            cell_row, cell_column
//   out      out_valid/out_stall, cell_data, cursor_row,          result out
//            cursor_column, scrolled
//   cfg      cfg_we, cfg_wdata                                  text_color write
//
// Printable put, backspace and read pass ST_ROW, ST_ADDR and ST_MEM; return,
// backspace at column 0 and out-of-range read go straight to ST_RESP. Tab
// repeats those steps per space; newline and a row wrap pass ST_NEWLINE, and a
// scroll blanks the new bottom row (rows rotate by a top-row pointer).
// After reset the back end clears ROWS*COLUMNS cells, one per cycle, with
// in_stall high. A 4-entry queue lets the front take requests while the back
// end works or out_stall holds a finished result.
`default_nettype none

module text_mode_terminal_top import txt_pkg::*; #(
	parameter int COLUMNS  = 80,
	parameter int ROWS     = 25,
	parameter int TAB_STOP = 4
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_we,
	input  wire logic [CHAR_W-1:0] cfg_wdata,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire logic              operation,
	input  wire logic [CHAR_W-1:0] char_code,
	input  wire logic [ROW_W-1:0]  cell_row,
	input  wire logic [COL_W-1:0]  cell_column,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output logic [CELL_W-1:0]      cell_data,
	output logic [ROW_W-1:0]       cursor_row,
	output logic [COL_W-1:0]       cursor_column,
	output logic                   scrolled
);

	logic         push;
	queue_entry_t push_entry;
	logic         queue_full;
	logic         queue_empty;
	logic         queue_pop;
	queue_entry_t queue_head;
	logic         clearing;

	txt_front #(
		.COLUMNS (COLUMNS),
		.ROWS    (ROWS)
	) u_front (
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.operation   (operation),
		.char_code   (char_code),
		.cell_row    (cell_row),
		.cell_column (cell_column),
		.queue_full  (queue_full),
		.clearing    (clearing),
		.push        (push),
		.push_entry  (push_entry)
	);

	txt_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.full       (queue_full),
		.pop        (queue_pop),
		.empty      (queue_empty),
		.head       (queue_head)
	);

	txt_back #(
		.COLUMNS  (COLUMNS),
		.ROWS     (ROWS),
		.TAB_STOP (TAB_STOP)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.fifo_empty    (queue_empty),
		.fifo_head     (queue_head),
		.fifo_pop      (queue_pop),
		.clearing      (clearing),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.cell_data     (cell_data),
		.cursor_row    (cursor_row),
		.cursor_column (cursor_column),
		.scrolled      (scrolled)
	);

endmodule

`default_nettype wire

/* rtl/txt_front.sv */
// txt_front: request intake and classification into the command queue
`default_nettype none

module txt_front import txt_pkg::*; #(
	parameter int COLUMNS,
	parameter int ROWS
) (
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire logic              operation,
	input  wire logic [CHAR_W-1:0] char_code,
	input  wire logic [ROW_W-1:0]  cell_row,
	input  wire logic [COL_W-1:0]  cell_column,
	input  wire logic              queue_full,
	input  wire logic              clearing,
	output logic                   push,
	output queue_entry_t           push_entry
);

	logic  out_of_range;
	kind_t kind;

	assign out_of_range = (32'(cell_row) >= 32'(ROWS)) || (32'(cell_column) >= 32'(COLUMNS));

	always_comb begin
		kind = KIND_PUT_CHAR;
		if (operation == OP_READ) begin
			kind = out_of_range ? KIND_READ_NONE : KIND_READ;
		end else begin
			case (char_code)
				CH_NEWLINE:   kind = KIND_NEWLINE;
				CH_RETURN:    kind = KIND_RETURN;
				CH_TAB:       kind = KIND_TAB;
				CH_BACKSPACE: kind = KIND_BACKSPACE;
				default:      kind = KIND_PUT_CHAR;
			endcase
		end
	end

	assign in_stall        = queue_full || clearing || !arst_n;
	assign push            = in_valid && !in_stall;
	assign push_entry.kind = kind;
	assign push_entry.ch   = char_code;
	assign push_entry.row  = cell_row;
	assign push_entry.col  = cell_column;

endmodule

`default_nettype wire

/* rtl/txt_queue.sv */
// txt_queue: short command queue between front and back
`default_nettype none

module txt_queue import txt_pkg::*; (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         push,
	input  queue_entry_t      push_entry,
	output logic              full,
	input  wire logic         pop,
	output logic              empty,
	output queue_entry_t      head
);

	queue_entry_t        entries_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q;
	logic [QPTR_W-1:0]   rd_ptr_q;
	logic [QPTR_W:0]     count_q;

	assign full  = (count_q == (QPTR_W+1)'(QUEUE_DEPTH));
	assign empty = (count_q == '0);
	assign head  = entries_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			entries_q[wr_ptr_q] <= push_entry;
	end

endmodule

`default_nettype wire

/* rtl/txt_back.sv */
// txt_back: command execution, screen store, cursor and result register
`default_nettype none

module txt_back import txt_pkg::*; #(
	parameter int COLUMNS,
	parameter int ROWS,
	parameter int TAB_STOP
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_we,
	input  wire logic [CHAR_W-1:0] cfg_wdata,
	input  wire logic              fifo_empty,
	input  queue_entry_t           fifo_head,
	output logic                   fifo_pop,
	output logic                   clearing,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output logic [CELL_W-1:0]      cell_data,
	output logic [ROW_W-1:0]       cursor_row,
	output logic [COL_W-1:0]       cursor_column,
	output logic                   scrolled
);

	localparam int RW    = $clog2(ROWS);
	localparam int CW    = $clog2(COLUMNS);
	localparam int TOTAL = ROWS * COLUMNS;
	localparam int AW    = $clog2(TOTAL);
	localparam int TMW   = $clog2(TAB_STOP + 1);

	localparam logic [RW-1:0]  ROW_LAST  = RW'(ROWS - 1);
	localparam logic [RW:0]    ROWS_V    = (RW+1)'(ROWS);
	localparam logic [CW-1:0]  COL_LAST  = CW'(COLUMNS - 1);
	localparam logic [TMW-1:0] TAB_LAST  = TMW'(TAB_STOP - 1);
	localparam logic [AW-1:0]  ADDR_LAST = AW'(TOTAL - 1);
	localparam logic [AW-1:0]  COLS_A    = AW'(COLUMNS);

	back_state_t        state_q, state_d;
	logic [CHAR_W-1:0]  color_q;
	logic [RW-1:0]      top_q;
	logic [RW-1:0]      cur_row_q;
	logic [CW-1:0]      cur_col_q;
	logic [TMW-1:0]     colmod_q;
	logic               scrolled_q;
	logic [AW-1:0]      addr_q;
	logic [CW-1:0]      cnt_q;
	kind_t              kind_q;
	logic [CHAR_W-1:0]  ch_q;
	logic [RW-1:0]      rrow_q;
	logic [CW-1:0]      rcol_q;
	logic [RW-1:0]      prow_q;
	logic [CELL_W-1:0]  rdata_q;
	logic               out_valid_q;
	logic [CELL_W-1:0]  out_data_q;
	logic [ROW_W-1:0]   out_row_q;
	logic [COL_W-1:0]   out_col_q;
	logic               out_scrolled_q;
	logic [CELL_W-1:0]  mem_q [TOTAL];

	logic               mem_we;
	logic               mem_re;
	logic [CELL_W-1:0]  mem_wdata;
	logic               out_load;
	logic [RW-1:0]      row_pick;
	logic [CW-1:0]      col_pick;
	logic [RW:0]        psum;
	logic [RW-1:0]      prow;
	logic [TMW-1:0]     colmod_inc;
	logic [TMW-1:0]     colmod_dec;
	logic [RW-1:0]      top_inc;

	assign row_pick   = (kind_q == KIND_READ) ? rrow_q : cur_row_q;
	assign col_pick   = (kind_q == KIND_READ) ? rcol_q : cur_col_q;
	assign psum       = (RW+1)'(top_q) + (RW+1)'(row_pick);
	assign prow       = (psum >= ROWS_V) ? RW'(psum - ROWS_V) : RW'(psum);
	assign colmod_inc = (colmod_q == TAB_LAST) ? '0 : colmod_q + 1'b1;
	assign colmod_dec = (colmod_q == '0) ? TAB_LAST : colmod_q - 1'b1;
	assign top_inc    = (top_q == ROW_LAST) ? '0 : top_q + 1'b1;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (addr_q == ADDR_LAST)
					state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (!fifo_empty) begin
					case (fifo_head.kind)
						KIND_READ, KIND_TAB, KIND_PUT_CHAR: state_d = ST_ROW;
						KIND_NEWLINE:                       state_d = ST_NEWLINE;
						KIND_BACKSPACE:
							state_d = (cur_col_q == '0) ? ST_RESP : ST_ROW;
						default:                            state_d = ST_RESP;
					endcase
				end
			end
			ST_ROW:  state_d = ST_ADDR;
			ST_ADDR: state_d = ST_MEM;
			ST_MEM: begin
				if (kind_q == KIND_READ || kind_q == KIND_BACKSPACE)
					state_d = ST_RESP;
				else if (cur_col_q == COL_LAST)
					state_d = ST_NEWLINE;
				else if (kind_q == KIND_TAB && colmod_q != TAB_LAST)
					state_d = ST_ROW;
				else
					state_d = ST_RESP;
			end
			ST_NEWLINE: state_d = (cur_row_q == ROW_LAST) ? ST_BLANK : ST_RESP;
			ST_BLANK: begin
				if (cnt_q == COL_LAST)
					state_d = ST_RESP;
			end
			ST_RESP: begin
				if (out_load)
					state_d = ST_IDLE;
			end
			default: state_d = ST_CLEAR;
		endcase
	end

	// control outputs
	always_comb begin
		fifo_pop  = 1'b0;
		mem_we    = 1'b0;
		mem_re    = 1'b0;
		mem_wdata = RESET_CELL;
		out_load  = 1'b0;
		case (state_q)
			ST_CLEAR: mem_we = 1'b1;
			ST_IDLE:  fifo_pop = !fifo_empty;
			ST_MEM: begin
				if (kind_q == KIND_READ) begin
					mem_re = 1'b1;
				end else begin
					mem_we    = 1'b1;
					mem_wdata = {color_q, (kind_q == KIND_PUT_CHAR) ? ch_q : CH_SPACE};
				end
			end
			ST_BLANK: begin
				mem_we    = 1'b1;
				mem_wdata = {color_q, CH_SPACE};
			end
			ST_RESP:  out_load = !out_valid_q || !out_stall;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_CLEAR;
			color_q        <= RESET_COLOR;
			top_q          <= '0;
			cur_row_q      <= '0;
			cur_col_q      <= '0;
			colmod_q       <= '0;
			scrolled_q     <= 1'b0;
			addr_q         <= '0;
			cnt_q          <= '0;
			out_valid_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we)
				color_q <= cfg_wdata;
			if (out_load)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
			case (state_q)
				ST_CLEAR: addr_q <= addr_q + 1'b1;
				ST_IDLE: begin
					if (!fifo_empty) begin
						scrolled_q <= 1'b0;
						if (fifo_head.kind == KIND_RETURN) begin
							cur_col_q <= '0;
							colmod_q  <= '0;
						end else if (fifo_head.kind == KIND_BACKSPACE && cur_col_q != '0) begin
							cur_col_q <= cur_col_q - 1'b1;
							colmod_q  <= colmod_dec;
						end
					end
				end
				ST_ADDR: addr_q <= AW'(prow_q) * COLS_A + AW'(col_pick);
				ST_MEM: begin
					if ((kind_q == KIND_PUT_CHAR || kind_q == KIND_TAB) && cur_col_q != COL_LAST) begin
						cur_col_q <= cur_col_q + 1'b1;
						colmod_q  <= colmod_inc;
					end
				end
				ST_NEWLINE: begin
					cur_col_q <= '0;
					colmod_q  <= '0;
					if (cur_row_q == ROW_LAST) begin
						// old top row becomes the new bottom row
						top_q      <= top_inc;
						scrolled_q <= 1'b1;
						addr_q     <= AW'(top_q) * COLS_A;
						cnt_q      <= '0;
					end else begin
						cur_row_q <= cur_row_q + 1'b1;
					end
				end
				ST_BLANK: begin
					addr_q <= addr_q + 1'b1;
					cnt_q  <= cnt_q + 1'b1;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && !fifo_empty) begin
			kind_q <= fifo_head.kind;
			ch_q   <= fifo_head.ch;
			rrow_q <= RW'(fifo_head.row);
			rcol_q <= CW'(fifo_head.col);
		end
		if (state_q == ST_ROW)
			prow_q <= prow;
		if (out_load) begin
			out_data_q     <= (kind_q == KIND_READ) ? rdata_q : '0;
			out_row_q      <= ROW_W'(cur_row_q);
			out_col_q      <= COL_W'(cur_col_q);
			out_scrolled_q <= scrolled_q;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we)
			mem_q[addr_q] <= mem_wdata;
		if (mem_re)
			rdata_q <= mem_q[addr_q];
	end

	assign clearing      = (state_q == ST_CLEAR);
	assign out_valid     = out_valid_q;
	assign cell_data     = out_data_q;
	assign cursor_row    = out_row_q;
	assign cursor_column = out_col_q;
	assign scrolled      = out_scrolled_q;

	a_cursor_range: assert property (@(posedge clk) disable iff (!arst_n)
		cur_col_q <= COL_LAST && cur_row_q <= ROW_LAST && top_q <= ROW_LAST)
		else $error("cursor or top row out of range");

	a_scroll_start: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_NEWLINE && cur_row_q == ROW_LAST)
		|=> (state_q == ST_BLANK && scrolled_q && cur_col_q == '0))
		else $error("newline on last row did not start a scroll");

	a_blank_len: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_BLANK && cnt_q == COL_LAST) |=> (state_q == ST_RESP))
		else $error("row blanking overran");

	a_addr_range: assert property (@(posedge clk) disable iff (!arst_n)
		(mem_we || mem_re) |-> (addr_q <= ADDR_LAST))
		else $error("screen address out of range");

endmodule

`default_nettype wire

/* dv/text_mode_terminal_checker.sv */
// Text terminal checker: tracks screen, cursor and color, predicts each reply and compares it.
module text_mode_terminal_checker import txt_pkg::*; #(
	parameter int COLUMNS  = 80,
	parameter int ROWS     = 25,
	parameter int TAB_STOP = 4
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [CHAR_W-1:0] cfg_wdata,
	input  logic              in_valid,
	input  logic              in_stall,
	input  logic              operation,
	input  logic [CHAR_W-1:0] char_code,
	input  logic [ROW_W-1:0]  cell_row,
	input  logic [COL_W-1:0]  cell_column,
	input  logic              out_valid,
	input  logic              out_stall,
	input  logic [CELL_W-1:0] cell_data,
	input  logic [ROW_W-1:0]  cursor_row,
	input  logic [COL_W-1:0]  cursor_column,
	input  logic              scrolled,
	output int                fail_count,
	output int                pending
);

	typedef struct packed {
		logic [CELL_W-1:0] data;
		logic [ROW_W-1:0]  row;
		logic [COL_W-1:0]  col;
		logic              scroll;
	} reply_t;

	logic [CELL_W-1:0] screen [ROWS*COLUMNS];
	int                cur_row;
	int                cur_col;
	logic [CHAR_W-1:0] color;
	bit                rolled;
	reply_t            expected_replies[$];
	reply_t            want;

	task automatic scroll_screen();
		for (int i = 0; i < (ROWS-1)*COLUMNS; i++)
			screen[i] = screen[i+COLUMNS];
		for (int c = 0; c < COLUMNS; c++)
			screen[(ROWS-1)*COLUMNS + c] = {color, CH_SPACE};
		rolled = 1'b1;
	endtask

	task automatic new_line();
		cur_col = 0;
		if (cur_row + 1 >= ROWS)
			scroll_screen();
		else
			cur_row++;
	endtask

	task automatic place_glyph(input logic [CHAR_W-1:0] ch);
		screen[cur_row*COLUMNS + cur_col] = {color, ch};
		cur_col++;
		if (cur_col >= COLUMNS)
			new_line();
	endtask

	task automatic print_char(input logic [CHAR_W-1:0] ch);
		if (ch == CH_NEWLINE) begin
			new_line();
		end else if (ch == CH_RETURN) begin
			cur_col = 0;
		end else if (ch == CH_TAB) begin
			do
				place_glyph(CH_SPACE);
			while (cur_col % TAB_STOP != 0);
		end else if (ch == CH_BACKSPACE) begin
			if (cur_col > 0) begin
				cur_col--;
				screen[cur_row*COLUMNS + cur_col] = {color, CH_SPACE};
			end
		end else begin
			place_glyph(ch);
		end
	endtask

	task automatic apply_request(input logic op, input logic [CHAR_W-1:0] ch,
			input logic [ROW_W-1:0] r, input logic [COL_W-1:0] c);
		reply_t rep;
		rolled = 1'b0;
		rep.data = '0;
		if (op == OP_PUT)
			print_char(ch);
		else if (int'(r) < ROWS && int'(c) < COLUMNS)
			rep.data = screen[int'(r)*COLUMNS + int'(c)];
		rep.row    = ROW_W'(cur_row);
		rep.col    = COL_W'(cur_col);
		rep.scroll = rolled;
		expected_replies.push_back(rep);
	endtask

	task automatic check_field(input string name, input int exp_val, input int act_val);
		if (exp_val != act_val) begin
			$display("%0t: %s mismatch, expected %0h actual %0h",
				$time, name, exp_val, act_val);
			fail_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < ROWS*COLUMNS; i++)
				screen[i] = RESET_CELL;
			cur_row = 0;
			cur_col = 0;
			color   = RESET_COLOR;
			expected_replies.delete();
			fail_count = 0;
			pending    = 0;
		end else begin
			if (cfg_we)
				color = cfg_wdata;
			if (out_valid && !out_stall) begin
				if (expected_replies.size() == 0) begin
					$display("%0t: unexpected result, expected none actual cell %h row %0d col %0d scrolled %0b",
						$time, cell_data, cursor_row, cursor_column, scrolled);
					fail_count++;
				end else begin
					want = expected_replies.pop_front();
					check_field("cell_data", want.data, cell_data);
					check_field("cursor_row", want.row, cursor_row);
					check_field("cursor_column", want.col, cursor_column);
					check_field("scrolled", want.scroll, scrolled);
				end
			end
			if (in_valid && !in_stall)
				apply_request(operation, char_code, cell_row, cell_column);
			pending = expected_replies.size();
		end
	end

endmodule

/* dv/text_mode_terminal_top_tb.sv */
// Text terminal testbench top: clock, reset, request stimulus, stalls, color phases, verdict.
module text_mode_terminal_top_tb;
	import txt_pkg::*;

	localparam int COLUMNS  = 80;
	localparam int ROWS     = 25;
	localparam int TAB_STOP = 4;

	logic              clk         = 1'b0;
	logic              arst_n      = 1'b0;
	logic              cfg_we      = 1'b0;
	logic [CHAR_W-1:0] cfg_wdata   = '0;
	logic              in_valid    = 1'b0;
	logic              in_stall;
	logic              operation   = OP_PUT;
	logic [CHAR_W-1:0] char_code   = '0;
	logic [ROW_W-1:0]  cell_row    = '0;
	logic [COL_W-1:0]  cell_column = '0;
	logic              out_valid;
	logic              out_stall   = 1'b0;
	logic [CELL_W-1:0] cell_data;
	logic [ROW_W-1:0]  cursor_row;
	logic [COL_W-1:0]  cursor_column;
	logic              scrolled;

	int fail_count;
	int pending;
	int sent         = 0;
	bit stall_on     = 1'b0;
	bit sender_idles = 1'b1;
	int stall_run    = 0;
	int stall_pick;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	text_mode_terminal_top #(
		.COLUMNS(COLUMNS), .ROWS(ROWS), .TAB_STOP(TAB_STOP)
	) dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.in_valid(in_valid), .in_stall(in_stall),
		.operation(operation), .char_code(char_code),
		.cell_row(cell_row), .cell_column(cell_column),
		.out_valid(out_valid), .out_stall(out_stall),
		.cell_data(cell_data), .cursor_row(cursor_row),
		.cursor_column(cursor_column), .scrolled(scrolled)
	);

	text_mode_terminal_checker #(
		.COLUMNS(COLUMNS), .ROWS(ROWS), .TAB_STOP(TAB_STOP)
	) terminal_check (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.in_valid(in_valid), .in_stall(in_stall),
		.operation(operation), .char_code(char_code),
		.cell_row(cell_row), .cell_column(cell_column),
		.out_valid(out_valid), .out_stall(out_stall),
		.cell_data(cell_data), .cursor_row(cursor_row),
		.cursor_column(cursor_column), .scrolled(scrolled),
		.fail_count(fail_count), .pending(pending)
	);

	// receiver backpressure: mostly open, short holds, rare long ones
	always @(posedge clk) begin
		if (!stall_on) begin
			out_stall <= 1'b0;
			stall_run <= 0;
		end else if (stall_run != 0) begin
			stall_run <= stall_run - 1;
		end else begin
			stall_pick = $urandom_range(0, 99);
			if (stall_pick < 70) begin
				out_stall <= 1'b0;
			end else begin
				out_stall <= 1'b1;
				stall_run <= (stall_pick < 95) ? $urandom_range(0, 2) : $urandom_range(10, 60);
			end
		end
	end

	function automatic int pick_gap();
		int p;
		p = $urandom_range(0, 99);
		if (!sender_idles || p < 60)
			return 0;
		if (p < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 50);
	endfunction

	task automatic send(input logic op, input logic [CHAR_W-1:0] ch,
			input logic [ROW_W-1:0] r, input logic [COL_W-1:0] c);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid    <= 1'b1;
		operation   <= op;
		char_code   <= ch;
		cell_row    <= r;
		cell_column <= c;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		sent++;
	endtask

	task automatic put(input logic [CHAR_W-1:0] ch);
		send(OP_PUT, ch, ROW_W'($urandom), COL_W'($urandom));
	endtask

	task automatic read_cell(input logic [ROW_W-1:0] r, input logic [COL_W-1:0] c);
		send(OP_READ, CHAR_W'($urandom), r, c);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic set_color(input logic [CHAR_W-1:0] value);
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic run_phase(input int count);
		int stop;
		int kind;
		int n;
		logic [CHAR_W-1:0] ch;
		stop = sent + count;
		while (sent < stop) begin
			kind = $urandom_range(0, 99);
			if (kind < 40) begin
				n = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 100) : $urandom_range(1, 20);
				repeat (n) begin
					ch = ($urandom_range(0, 3) == 0) ? CHAR_W'($urandom)
						: CHAR_W'($urandom_range(8'h20, 8'h7e));
					put(ch);
				end
			end else if (kind < 55) begin
				repeat ($urandom_range(1, 3)) put(CH_NEWLINE);
			end else if (kind < 63) begin
				put(CH_TAB);
			end else if (kind < 71) begin
				repeat ($urandom_range(1, 3)) put(CH_BACKSPACE);
			end else if (kind < 75) begin
				put(CH_RETURN);
			end else if (kind < 95) begin
				repeat ($urandom_range(1, 4)) begin
					if ($urandom_range(0, 7) == 0)
						read_cell(ROW_W'($urandom), COL_W'($urandom));
					else
						read_cell(ROW_W'($urandom_range(0, ROWS-1)),
							COL_W'($urandom_range(0, COLUMNS-1)));
				end
			end else begin
				send(1'($urandom), CHAR_W'($urandom), ROW_W'($urandom), COL_W'($urandom));
			end
		end
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		stall_on <= 1'b1;

		// reset color, screen edges, out-of-range reads, each control character
		read_cell(5'd0, 7'd0);
		read_cell(5'd24, 7'd79);
		read_cell(5'd25, 7'd0);
		read_cell(5'd0, 7'd80);
		read_cell(5'd31, 7'd127);
		put(8'h41);
		put(8'h00);
		put(8'hFF);
		put(CH_BACKSPACE);
		put(CH_TAB);
		put(CH_TAB);
		put(CH_RETURN);
		put(CH_BACKSPACE);
		put(CH_NEWLINE);
		put(8'h7F);
		send(OP_PUT, 8'h5A, 5'h1F, 7'h7F);
		read_cell(5'd0, 7'd0);
		read_cell(5'd0, 7'd2);
		read_cell(5'd0, 7'd5);
		read_cell(5'd1, 7'd0);
		read_cell(5'd1, 7'd1);
		drain();

		set_color(8'hFF);
		run_phase(260);
		drain();

		set_color(8'h00);
		run_phase(260);
		drain();

		set_color(CHAR_W'($urandom));
		run_phase(130);
		drain();
		run_phase(130);
		drain();

		sender_idles = 1'b0;
		stall_on <= 1'b0;
		set_color(CHAR_W'($urandom));
		run_phase(240);
		drain();

		repeat (100) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	initial begin
		#10_000_000;
		$display("TB_ERROR");
		$finish;
	end

endmodule

/* text_mode_terminal_top.f */
rtl/txt_pkg.sv
rtl/txt_front.sv
rtl/txt_queue.sv
rtl/txt_back.sv
rtl/text_mode_terminal_top.sv
dv/text_mode_terminal_checker.sv
dv/text_mode_terminal_top_tb.sv
